FILE: rtl/tlpf_pkg.sv
// shared constants, codes and helpers for the tile layer pixel fetch block
package tlpf_pkg;

  // video memory geometry; offsets wrap at the memory size
  localparam int unsigned VRAM_BYTES = 131072;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_BYTES);
  localparam logic [23:0] VRAM_START = 24'h040000;

  localparam int unsigned PAL_BYTES = 512;
  localparam int unsigned PAL_AW    = $clog2(PAL_BYTES);

  localparam int unsigned SCREEN_COLUMNS = 320;
  localparam int unsigned SCREEN_ROWS    = 180;
  localparam int unsigned LAYER_NUMBER   = 0;

  // defaults for config fields written as zero
  localparam logic [23:0] DEF_MAP_BASE     = 24'(32'h04C000 + LAYER_NUMBER * 32'h2000);
  localparam logic [23:0] DEF_PATTERN_BASE = 24'h040000;
  localparam logic [15:0] DEF_COLUMNS      = 16'd64;
  localparam logic [15:0] DEF_ROWS         = 16'd32;

  // field widths
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned ADDRESS_W = 17;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned SX_W      = 9;
  localparam int unsigned SY_W      = 8;
  localparam int unsigned RGB_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  // world position is screen plus scroll, tile coordinate drops three bits
  localparam int unsigned WORLD_W = 17;
  localparam int unsigned TILE_W  = WORLD_W - 3;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_VRAM_WR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PAL_WR  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RENDER  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ADDRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_ADDRESS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_V     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_OFFSET   = 3'd7;

  // layer mode bits
  localparam int unsigned MODE_ENABLE = 0;
  localparam int unsigned MODE_TRANSP = 1;
  localparam int unsigned MODE_WRAP_X = 2;
  localparam int unsigned MODE_WRAP_Y = 3;

  // map entry fields
  localparam int unsigned ENTRY_FLIP_X = 14;
  localparam int unsigned ENTRY_FLIP_Y = 15;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_MUL,
    ST_MAP_LO,
    ST_MAP_HI,
    ST_PAT,
    ST_PAL_LO,
    ST_PAL_HI,
    ST_RESULT
  } state_e;

  // rgb555 to rgb888, each channel replicates its top bits
  function automatic logic [RGB_W-1:0] expand555(input logic [15:0] v);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = v[14:10];
    g = v[9:5];
    b = v[4:0];
    return {r, r[4:2], g, g[4:2], b, b[4:2]};
  endfunction

endpackage

FILE: rtl/tlpf_req_if.sv
// request channel: memory writes and pixel render requests
interface tlpf_req_if import tlpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [ADDRESS_W-1:0] address;
  logic [DATA_W-1:0]    data;
  logic [SX_W-1:0]      screen_x;
  logic [SY_W-1:0]      screen_y;

  modport source (output valid, action, address, data, screen_x, screen_y, input ready);
  modport sink   (input valid, action, address, data, screen_x, screen_y, output ready);
endinterface

FILE: rtl/tlpf_rsp_if.sv
// result channel: one word per rendered pixel
interface tlpf_rsp_if import tlpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             drawn;
  logic [RGB_W-1:0] color_rgb;

  modport source (output valid, drawn, color_rgb, input ready);
  modport sink   (input valid, drawn, color_rgb, output ready);
endinterface

FILE: rtl/tile_layer_pixel_fetch.sv
// tile background layer pixel fetch: vram, palette, sequencer and result register
//
// req_i takes one word per valid/ready handshake: a video memory byte write,
// a palette byte write or a pixel render request. action 3 is taken and dropped.
// rsp_o gives one word (drawn, color_rgb) for every render request, in order.
// Writes give no word. A render runs from accept to accept through a
// map-size multiply, two map byte reads, one pattern read, two palette
// reads and the result write, on the single port of each memory. With
// wrap x or wrap y set, the tile position goes through a restoring
// remainder unit first, one bit per cycle. Disabled, off-screen, off-map
// and transparent pixels leave early. The block holds one request at a
// time; ready is high only between requests.
// The result sits in an output register, so the next request is accepted
// while it waits. A finished render that finds the register still full waits
// until rsp_o.ready frees it.
// After reset a sweep over all VRAM_BYTES (131072) addresses clears both
// memories while req_i.ready stays low; config writes are taken as ever. Config
// registers reset to zero; the user writes them only while idle (not enforced).
module tile_layer_pixel_fetch import tlpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  tlpf_req_if.sink             req_i,
  tlpf_rsp_if.source           rsp_o
);

  // config registers
  logic [3:0]  layer_mode_q;
  logic [23:0] map_address_q;
  logic [23:0] pattern_address_q;
  logic [15:0] scroll_h_q;
  logic [15:0] scroll_v_q;
  logic [15:0] map_columns_q;
  logic [15:0] map_rows_q;
  logic [7:0]  pal_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_mode_q      <= '0;
      map_address_q     <= '0;
      pattern_address_q <= '0;
      scroll_h_q        <= '0;
      scroll_v_q        <= '0;
      map_columns_q     <= '0;
      map_rows_q        <= '0;
      pal_offset_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LAYER_MODE:  layer_mode_q      <= cfg_data_i[3:0];
        REG_MAP_ADDRESS: map_address_q     <= cfg_data_i;
        REG_PAT_ADDRESS: pattern_address_q <= cfg_data_i;
        REG_SCROLL_H:    scroll_h_q        <= cfg_data_i[15:0];
        REG_SCROLL_V:    scroll_v_q        <= cfg_data_i[15:0];
        REG_MAP_COLUMNS: map_columns_q     <= cfg_data_i[15:0];
        REG_MAP_ROWS:    map_rows_q        <= cfg_data_i[15:0];
        REG_PAL_OFFSET:  pal_offset_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective layout, zero fields take the defaults
  logic [15:0]        cols;
  logic [15:0]        rows;
  logic [23:0]        map_base;
  logic [23:0]        pat_base;
  logic [VRAM_AW-1:0] map_off;
  logic [VRAM_AW-1:0] pat_off;

  assign cols     = (map_columns_q != '0) ? map_columns_q : DEF_COLUMNS;
  assign rows     = (map_rows_q != '0) ? map_rows_q : DEF_ROWS;
  assign map_base = (map_address_q != '0) ? map_address_q : DEF_MAP_BASE;
  assign pat_base = (pattern_address_q != '0) ? pattern_address_q : DEF_PATTERN_BASE;
  // only the low address bits survive the wrap at the memory size
  assign map_off  = map_base[VRAM_AW-1:0] - VRAM_START[VRAM_AW-1:0];
  assign pat_off  = pat_base[VRAM_AW-1:0] - VRAM_START[VRAM_AW-1:0];

  // memories
  logic [7:0] vram_mem [VRAM_BYTES];
  logic [7:0] pal_mem  [PAL_BYTES];

  logic               vram_we;
  logic               vram_re;
  logic [VRAM_AW-1:0] vram_addr;
  logic [7:0]         vram_wdata;
  logic [7:0]         vram_rdata_q;
  logic               pal_we;
  logic               pal_re;
  logic [PAL_AW-1:0]  pal_addr;
  logic [7:0]         pal_wdata;
  logic [7:0]         pal_rdata_q;

  always_ff @(posedge clk_i) begin
    if (vram_we) begin
      vram_mem[vram_addr] <= vram_wdata;
    end
    if (vram_re) begin
      vram_rdata_q <= vram_mem[vram_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[pal_addr] <= pal_wdata;
    end
    if (pal_re) begin
      pal_rdata_q <= pal_mem[pal_addr];
    end
  end

  // sequencer state
  state_e              st_q, st_d;
  logic [VRAM_AW-1:0]  clr_q, clr_d;
  logic [3:0]          step_q, step_d;
  logic [TILE_W-1:0]   tx_q, tx_d;
  logic [TILE_W-1:0]   ty_q, ty_d;
  logic [2:0]          px_q, px_d;
  logic [2:0]          py_q, py_d;
  logic [TILE_W+14:0]  dx_q, dx_d;
  logic [TILE_W+14:0]  dy_q, dy_d;
  logic [15:0]         prod_q, prod_d;
  logic [VRAM_AW-1:0]  addr_q, addr_d;
  logic [7:0]          lo_q, lo_d;
  logic [3:0]          pal_q, pal_d;
  logic                pxf_q, pxf_d;
  logic [7:0]          idx_q, idx_d;
  logic                drawn_q, drawn_d;
  logic                out_valid_q, out_valid_d;
  logic                out_drawn_q, out_drawn_d;
  logic [RGB_W-1:0]    out_color_q, out_color_d;

  logic [WORLD_W-1:0]  wx;
  logic [WORLD_W-1:0]  wy;
  logic                off_screen;
  logic [15:0]         entry;
  logic [2:0]          fpx;
  logic [2:0]          fpy;
  logic [3:0]          color;
  logic [15:0]         map_index;
  logic [29:0]         prod_full;
  logic                req_ready;

  assign wx = WORLD_W'(req_i.screen_x) + WORLD_W'(scroll_h_q);
  assign wy = WORLD_W'(req_i.screen_y) + WORLD_W'(scroll_v_q);
  assign off_screen = (13'(req_i.screen_x) >= 13'(SCREEN_COLUMNS)) ||
                      (13'(req_i.screen_y) >= 13'(SCREEN_ROWS));
  assign entry     = {vram_rdata_q, lo_q};
  assign fpx       = entry[ENTRY_FLIP_X] ? ~px_q : px_q;
  assign fpy       = entry[ENTRY_FLIP_Y] ? ~py_q : py_q;
  assign color     = pxf_q ? vram_rdata_q[3:0] : vram_rdata_q[7:4];
  assign map_index = prod_q + 16'(tx_q);
  assign prod_full = 30'(ty_q) * 30'(cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q      <= step_d;
    tx_q        <= tx_d;
    ty_q        <= ty_d;
    px_q        <= px_d;
    py_q        <= py_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    prod_q      <= prod_d;
    addr_q      <= addr_d;
    lo_q        <= lo_d;
    pal_q       <= pal_d;
    pxf_q       <= pxf_d;
    idx_q       <= idx_d;
    drawn_q     <= drawn_d;
    out_drawn_q <= out_drawn_d;
    out_color_q <= out_color_d;
  end

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    step_d      = step_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    px_d        = px_q;
    py_d        = py_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    prod_d      = prod_q;
    addr_d      = addr_q;
    lo_d        = lo_q;
    pal_d       = pal_q;
    pxf_d       = pxf_q;
    idx_d       = idx_q;
    drawn_d     = drawn_q;
    out_drawn_d = out_drawn_q;
    out_color_d = out_color_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    req_ready   = 1'b0;
    vram_we     = 1'b0;
    vram_re     = 1'b0;
    vram_addr   = addr_q;
    vram_wdata  = req_i.data;
    pal_we      = 1'b0;
    pal_re      = 1'b0;
    pal_addr    = {idx_q, 1'b0};
    pal_wdata   = req_i.data;

    unique case (st_q)
      ST_CLEAR: begin
        vram_we    = 1'b1;
        vram_addr  = clr_q;
        vram_wdata = '0;
        pal_we     = 1'b1;
        pal_addr   = clr_q[PAL_AW-1:0];
        pal_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == VRAM_AW'(VRAM_BYTES - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        vram_addr = req_i.address[VRAM_AW-1:0];
        pal_addr  = req_i.address[PAL_AW-1:0];
        tx_d      = wx[WORLD_W-1:3];
        ty_d      = wy[WORLD_W-1:3];
        px_d      = wx[2:0];
        py_d      = wy[2:0];
        dx_d      = {cols, 13'b0};
        dy_d      = {rows, 13'b0};
        step_d    = 4'(TILE_W - 1);
        drawn_d   = 1'b0;
        if (req_i.valid) begin
          case (req_i.action)
            ACT_VRAM_WR: vram_we = 1'b1;
            ACT_PAL_WR:  pal_we = 1'b1;
            ACT_RENDER: begin
              if (!layer_mode_q[MODE_ENABLE] || off_screen) begin
                st_d = ST_RESULT;
              end else if (layer_mode_q[MODE_WRAP_X] || layer_mode_q[MODE_WRAP_Y]) begin
                st_d = ST_WRAP;
              end else begin
                st_d = ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WRAP: begin
        // restoring remainder, divisor shifted down one place per cycle
        if (layer_mode_q[MODE_WRAP_X] && ((TILE_W + 15)'(tx_q) >= dx_q)) begin
          tx_d = tx_q - dx_q[TILE_W-1:0];
        end
        if (layer_mode_q[MODE_WRAP_Y] && ((TILE_W + 15)'(ty_q) >= dy_q)) begin
          ty_d = ty_q - dy_q[TILE_W-1:0];
        end
        dx_d   = dx_q >> 1;
        dy_d   = dy_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = prod_full[15:0];
        if ((16'(ty_q) >= rows) || (16'(tx_q) >= cols)) begin
          st_d = ST_RESULT;
        end else begin
          st_d = ST_MAP_LO;
        end
      end
      ST_MAP_LO: begin
        vram_re   = 1'b1;
        vram_addr = map_off + {map_index, 1'b0};
        addr_d    = vram_addr;
        st_d      = ST_MAP_HI;
      end
      ST_MAP_HI: begin
        vram_re   = 1'b1;
        vram_addr = addr_q + 1'b1;
        lo_d      = vram_rdata_q;
        st_d      = ST_PAT;
      end
      ST_PAT: begin
        // pattern row is four bytes, tile is 32 bytes
        vram_re   = 1'b1;
        vram_addr = pat_off + VRAM_AW'({entry[9:0], 5'b0}) +
                    VRAM_AW'({fpy, 2'b0}) + VRAM_AW'(fpx[2:1]);
        pal_d     = entry[13:10] + pal_offset_q[3:0];
        pxf_d     = fpx[0];
        st_d      = ST_PAL_LO;
      end
      ST_PAL_LO: begin
        idx_d = {pal_q, color};
        if (layer_mode_q[MODE_TRANSP] && (color == '0)) begin
          st_d = ST_RESULT;
        end else begin
          pal_re   = 1'b1;
          pal_addr = {pal_q, color, 1'b0};
          drawn_d  = 1'b1;
          st_d     = ST_PAL_HI;
        end
      end
      ST_PAL_HI: begin
        pal_re   = 1'b1;
        pal_addr = {idx_q, 1'b1};
        lo_d     = pal_rdata_q;
        st_d     = ST_RESULT;
      end
      ST_RESULT: begin
        // palette read data holds here while the result register is busy
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_drawn_d = drawn_q;
          out_color_d = drawn_q ? expand555({pal_rdata_q, lo_q}) : '0;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.drawn     = out_drawn_q;
  assign rsp_o.color_rgb = out_color_q;

  // a result word only appears out of the result state
  a_rsp_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(st_q == ST_RESULT))
    else $error("result word without a finished render");

  // memory writes only in the clearing sweep or on an accepted write word
  a_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vram_we || pal_we) |-> (st_q == ST_CLEAR || (st_q == ST_IDLE && req_i.valid)))
    else $error("memory write during a render");

  // after the remainder unit a wrapped tile column is inside the map width
  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL && $past(st_q == ST_WRAP) && layer_mode_q[MODE_WRAP_X])
      |-> (16'(tx_q) < cols))
    else $error("wrapped tile column not below map width");

endmodule

FILE: bench/tb_tile_layer_pixel_fetch.sv
// testbench for the tile layer pixel fetch block: shadow layer model, random words, stalls
module tb_tile_layer_pixel_fetch;
  import tlpf_pkg::*;

  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_WORDS   = 128;
  localparam int unsigned HOLD_PHASE    = 7;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned MAX_PRINTS    = 50;
  // clear sweep plus the slowest item many times over
  localparam int unsigned TIMEOUT_CYCLES = 1000000;

  // the block takes action 3 and drops it
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0]  action;
    logic [ADDRESS_W-1:0] address;
    logic [DATA_W-1:0]    data;
    logic [SX_W-1:0]      sx;
    logic [SY_W-1:0]      sy;
  } pix_req_t;

  typedef struct {
    logic             drawn;
    logic [RGB_W-1:0] color_rgb;
  } pix_out_t;

  typedef struct {
    logic [3:0]  mode;
    logic [23:0] map_base;
    logic [23:0] pat_base;
    logic [15:0] scroll_h;
    logic [15:0] scroll_v;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [7:0]  pal_ofs;
  } layer_cfg_t;

  // shadow copy of the layer: memories, registers and the pixels still due
  class layer_mirror;
    bit [7:0]    vram [VRAM_BYTES];
    bit [7:0]    pal [PAL_BYTES];
    bit [3:0]    mode;
    bit [23:0]   map_base;
    bit [23:0]   pat_base;
    bit [15:0]   scroll_h;
    bit [15:0]   scroll_v;
    bit [15:0]   map_cols;
    bit [15:0]   map_rows;
    bit [7:0]    pal_ofs;
    pix_out_t    pixels_due[$];
    int unsigned errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_LAYER_MODE:  mode = val[3:0];
        REG_MAP_ADDRESS: map_base = val[23:0];
        REG_PAT_ADDRESS: pat_base = val[23:0];
        REG_SCROLL_H:    scroll_h = val[15:0];
        REG_SCROLL_V:    scroll_v = val[15:0];
        REG_MAP_COLUMNS: map_cols = val[15:0];
        REG_MAP_ROWS:    map_rows = val[15:0];
        REG_PAL_OFFSET:  pal_ofs = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned vram_index(logic [31:0] a);
      return (a - 32'(VRAM_START)) % VRAM_BYTES;
    endfunction

    // map entry address and in-tile position; 0 when the layer is off or the pixel misses the screen or the map
    function bit locate(input logic [SX_W-1:0] sx, input logic [SY_W-1:0] sy,
                        output logic [31:0] ea, output logic [2:0] px,
                        output logic [2:0] py);
      logic [31:0] cols;
      logic [31:0] rows;
      logic [31:0] base;
      logic [31:0] wx;
      logic [31:0] wy;
      logic [31:0] tx;
      logic [31:0] ty;
      ea = '0;
      px = '0;
      py = '0;
      cols = (map_cols != 0) ? 32'(map_cols) : 32'(DEF_COLUMNS);
      rows = (map_rows != 0) ? 32'(map_rows) : 32'(DEF_ROWS);
      base = (map_base != 0) ? 32'(map_base) : 32'(DEF_MAP_BASE);
      if (!mode[MODE_ENABLE]) return 1'b0;
      if (sx >= SCREEN_COLUMNS || sy >= SCREEN_ROWS) return 1'b0;
      wx = 32'(sx) + 32'(scroll_h);
      wy = 32'(sy) + 32'(scroll_v);
      tx = wx >> 3;
      ty = wy >> 3;
      px = wx[2:0];
      py = wy[2:0];
      if (mode[MODE_WRAP_Y]) ty = ty % rows;
      if (mode[MODE_WRAP_X]) tx = tx % cols;
      if (ty >= rows || tx >= cols) return 1'b0;
      ea = base + (ty * cols + tx) * 2;
      return 1'b1;
    endfunction

    // pattern byte address after flips; odd picks the low nibble
    function logic [31:0] pattern_at(input logic [15:0] entry, input logic [2:0] px_in,
                                     input logic [2:0] py_in, output bit odd);
      logic [2:0]  px;
      logic [2:0]  py;
      logic [31:0] base;
      px = entry[ENTRY_FLIP_X] ? 3'd7 - px_in : px_in;
      py = entry[ENTRY_FLIP_Y] ? 3'd7 - py_in : py_in;
      base = (pat_base != 0) ? 32'(pat_base) : 32'(DEF_PATTERN_BASE);
      odd = px[0];
      return base + 32'(entry[9:0]) * 32 + 32'(py) * 4 + 32'(px >> 1);
    endfunction

    // byte offset of the low half of the palette word
    function logic [PAL_AW-1:0] palette_slot(logic [15:0] entry, logic [3:0] color);
      logic [3:0] row;
      row = entry[13:10] + pal_ofs[3:0];
      return {row, color, 1'b0};
    endfunction

    function pix_out_t shade_pixel(logic [SX_W-1:0] sx, logic [SY_W-1:0] sy);
      pix_out_t          r;
      logic [31:0]       ea;
      logic [31:0]       paddr;
      logic [2:0]        px;
      logic [2:0]        py;
      bit                odd;
      logic [15:0]       entry;
      logic [15:0]       pe;
      logic [7:0]        pbyte;
      logic [3:0]        color;
      logic [PAL_AW-1:0] slot;
      logic [7:0]        red;
      logic [7:0]        grn;
      logic [7:0]        blu;
      r.drawn = 1'b0;
      r.color_rgb = '0;
      if (!locate(sx, sy, ea, px, py)) return r;
      entry = {vram[vram_index(ea + 1)], vram[vram_index(ea)]};
      paddr = pattern_at(entry, px, py, odd);
      pbyte = vram[vram_index(paddr)];
      color = odd ? pbyte[3:0] : pbyte[7:4];
      if (mode[MODE_TRANSP] && color == 0) return r;
      slot = palette_slot(entry, color);
      pe = {pal[slot + 1], pal[slot]};
      red = {pe[14:10], 3'b000};
      grn = {pe[9:5], 3'b000};
      blu = {pe[4:0], 3'b000};
      red = red | (red >> 5);
      grn = grn | (grn >> 5);
      blu = blu | (blu >> 5);
      r.drawn = 1'b1;
      r.color_rgb = {red, grn, blu};
      return r;
    endfunction

    function void note_word(pix_req_t it);
      case (it.action)
        ACT_VRAM_WR: vram[vram_index(32'(it.address) + 32'(VRAM_START))] = it.data;
        ACT_PAL_WR:  pal[it.address[PAL_AW-1:0]] = it.data;
        ACT_RENDER:  pixels_due.push_back(shade_pixel(it.sx, it.sy));
        default: ;
      endcase
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(logic drawn, logic [RGB_W-1:0] color_rgb);
      pix_out_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel with none due: drawn %0d rgb %06h", drawn, color_rgb));
        return;
      end
      want = pixels_due.pop_front();
      if (drawn !== want.drawn)
        report($sformatf("drawn got %0d want %0d", drawn, want.drawn));
      if (color_rgb !== want.color_rgb)
        report($sformatf("color_rgb got %06h want %06h", color_rgb, want.color_rgb));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  tlpf_req_if req ();
  tlpf_rsp_if rsp ();

  tile_layer_pixel_fetch dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  layer_mirror sb;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold when asked
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        rsp.ready <= 1'b0;
        sink_hold--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_pixel(rsp.drawn, rsp.color_rgb);
  end

  // entered and left at a falling edge; valid stays high into the next word
  task automatic send_word(input logic [ACTION_W-1:0] action,
                           input logic [ADDRESS_W-1:0] address,
                           input logic [DATA_W-1:0] data,
                           input logic [SX_W-1:0] sx, input logic [SY_W-1:0] sy);
    pix_req_t it;
    it.action = action;
    it.address = address;
    it.data = data;
    it.sx = sx;
    it.sy = sy;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.action <= it.action;
    req.address <= it.address;
    req.data <= it.data;
    req.screen_x <= it.sx;
    req.screen_y <= it.sy;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_word(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_layer(input layer_cfg_t c);
    logic [CFG_DAT_W-1:0] vals [2**CFG_IDX_W];
    vals[REG_LAYER_MODE]  = CFG_DAT_W'(c.mode);
    vals[REG_MAP_ADDRESS] = CFG_DAT_W'(c.map_base);
    vals[REG_PAT_ADDRESS] = CFG_DAT_W'(c.pat_base);
    vals[REG_SCROLL_H]    = CFG_DAT_W'(c.scroll_h);
    vals[REG_SCROLL_V]    = CFG_DAT_W'(c.scroll_v);
    vals[REG_MAP_COLUMNS] = CFG_DAT_W'(c.cols);
    vals[REG_MAP_ROWS]    = CFG_DAT_W'(c.rows);
    vals[REG_PAL_OFFSET]  = CFG_DAT_W'(c.pal_ofs);
    for (int i = 0; i < 2**CFG_IDX_W; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return 16'd0;
    if (r < 7) return 16'($urandom_range(6, 1));
    if (r < 8) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_scroll();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 5) return 16'd0;
    if (r < 8) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    layer_cfg_t        c;
    logic [9:0]        tile_a;
    logic [9:0]        tile_b;
    logic [SX_W-1:0]   sx;
    logic [SY_W-1:0]   sy;
    logic [31:0]       ea;
    logic [31:0]       paddr;
    logic [2:0]        px;
    logic [2:0]        py;
    bit                odd;
    logic [15:0]       entry;
    logic [7:0]        pbyte;
    logic [3:0]        color;
    logic [PAL_AW-1:0] slot;
    int unsigned       pick;
    int unsigned       sent;

    sb = new();
    src_idle_pct = 33;
    sink_idle_pct = 47;
    sink_hold = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.action = ACT_VRAM_WR;
    req.address = '0;
    req.data = '0;
    req.screen_x = '0;
    req.screen_y = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // layer off after reset
    send_word(ACT_RENDER, '0, '0, 9'd0, 8'd0);
    wait_drained();
    c = '{default: '0};
    c.mode[MODE_ENABLE] = 1'b1;
    program_layer(c);

    // tile 1 palette 2 at map (0,0), plain colors through the default bases
    send_word(ACT_VRAM_WR, 17'h0C000, 8'h01, 9'h1FF, 8'hFF);
    send_word(ACT_VRAM_WR, 17'h0C001, 8'h08, 9'h000, 8'h00);
    send_word(ACT_VRAM_WR, 17'h00020, 8'hA5, 9'h1FF, 8'h00);
    send_word(ACT_PAL_WR, 17'd84, 8'hFF, 9'h000, 8'hFF);
    send_word(ACT_PAL_WR, 17'd85, 8'h7F, 9'h1FF, 8'hFF);
    send_word(ACT_RENDER, 17'h1FFFF, 8'hFF, 9'd0, 8'd0);
    send_word(ACT_RENDER, 17'h00000, 8'h00, 9'd1, 8'd0);
    // both flips at map (1,0)
    send_word(ACT_VRAM_WR, 17'h0C002, 8'h01, 9'h000, 8'h00);
    send_word(ACT_VRAM_WR, 17'h0C003, 8'hC0, 9'h000, 8'h00);
    send_word(ACT_VRAM_WR, 17'h0003F, 8'h0F, 9'h000, 8'h00);
    send_word(ACT_PAL_WR, 17'd30, 8'h1F, 9'h000, 8'h00);
    send_word(ACT_PAL_WR, 17'd31, 8'h00, 9'h000, 8'h00);
    send_word(ACT_RENDER, '0, '0, 9'd8, 8'd0);
    // screen edges and beyond
    send_word(ACT_RENDER, '0, '0, 9'(SCREEN_COLUMNS - 1), 8'(SCREEN_ROWS - 1));
    send_word(ACT_RENDER, '0, '0, 9'(SCREEN_COLUMNS), 8'd0);
    send_word(ACT_RENDER, '0, '0, 9'd0, 8'(SCREEN_ROWS));
    send_word(ACT_RENDER, '0, '0, 9'h1FF, 8'hFF);
    send_word(ACT_UNUSED, 17'h1FFFF, 8'hFF, 9'h1FF, 8'hFF);
    send_word(ACT_VRAM_WR, 17'h1FFFF, 8'hFF, 9'h1FF, 8'hFF);
    send_word(ACT_PAL_WR, 17'h1FFFF, 8'h00, 9'h1FF, 8'hFF);
    // color zero drawn while not transparent
    send_word(ACT_RENDER, '0, '0, 9'd2, 8'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct = (ph < 3) ? 33 : (ph < 6) ? 47 : 0;
      sink_idle_pct = (ph < 3) ? 47 : (ph < 6) ? 33 : 0;
      wait_drained();
      if (ph == 0) begin
        c.mode = 4'hF;
        c.map_base = 24'hFFFFFF;
        c.pat_base = 24'hFFFFFF;
        c.scroll_h = 16'hFFFF;
        c.scroll_v = 16'hFFFF;
        c.cols = 16'hFFFF;
        c.rows = 16'hFFFF;
        c.pal_ofs = 8'hFF;
      end else if (ph == 1) begin
        c = '{default: '0};
        c.mode[MODE_ENABLE] = 1'b1;
        c.mode[MODE_WRAP_X] = 1'b1;
        c.mode[MODE_WRAP_Y] = 1'b1;
      end else begin
        c.mode = 4'($urandom);
        if ($urandom_range(4) != 0) c.mode[MODE_ENABLE] = 1'b1;
        c.map_base = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom);
        c.pat_base = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom);
        c.scroll_h = pick_scroll();
        c.scroll_v = pick_scroll();
        c.cols = pick_size();
        c.rows = pick_size();
        c.pal_ofs = 8'($urandom);
      end
      program_layer(c);
      tile_a = 10'($urandom);
      tile_b = 10'($urandom);
      if (ph == HOLD_PHASE) sink_hold = HOLD_CYCLES;

      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if ($urandom_range(9) != 0) begin
          sx = 9'($urandom_range(SCREEN_COLUMNS - 1));
          sy = 8'($urandom_range(SCREEN_ROWS - 1));
        end else begin
          sx = 9'($urandom);
          sy = 8'($urandom);
        end
        if (pick < 55) begin
          // fill the entry, pattern byte and palette word this pixel reads
          if (sb.locate(sx, sy, ea, px, py)) begin
            if ($urandom_range(3) != 0) entry[9:0] = $urandom_range(1) ? tile_a : tile_b;
            else entry[9:0] = 10'($urandom);
            entry[15:10] = 6'($urandom);
            send_word(ACT_VRAM_WR, 17'(sb.vram_index(ea)), entry[7:0], 9'($urandom),
                      8'($urandom));
            send_word(ACT_VRAM_WR, 17'(sb.vram_index(ea + 1)), entry[15:8], 9'($urandom),
                      8'($urandom));
            paddr = sb.pattern_at(entry, px, py, odd);
            pbyte = 8'($urandom);
            if ($urandom_range(4) == 0) begin
              if (odd) pbyte[3:0] = 4'd0;
              else pbyte[7:4] = 4'd0;
            end
            send_word(ACT_VRAM_WR, 17'(sb.vram_index(paddr)), pbyte, 9'($urandom),
                      8'($urandom));
            color = odd ? pbyte[3:0] : pbyte[7:4];
            slot = sb.palette_slot(entry, color);
            send_word(ACT_PAL_WR, {8'($urandom), slot}, 8'($urandom), 9'($urandom),
                      8'($urandom));
            send_word(ACT_PAL_WR, {8'($urandom), slot + 9'd1}, 8'($urandom), 9'($urandom),
                      8'($urandom));
            sent += 5;
          end
          send_word(ACT_RENDER, 17'($urandom), 8'($urandom), sx, sy);
          sent++;
        end else if (pick < 75) begin
          send_word(ACT_RENDER, 17'($urandom), 8'($urandom), sx, sy);
          sent++;
        end else if (pick < 92) begin
          send_word(ACT_VRAM_WR, 17'($urandom), 8'($urandom), sx, sy);
          sent++;
        end else if (pick < 98) begin
          send_word(ACT_PAL_WR, 17'($urandom), 8'($urandom), sx, sy);
          sent++;
        end else begin
          send_word(ACT_UNUSED, 17'($urandom), 8'($urandom), sx, sy);
        end
      end
    end

    wait_drained();
    if (sb.pending() != 0) sb.report($sformatf("%0d pixels never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
